// File: design/oaht_pkg.sv
// shared types and constants for the open address hash table
// no dependencies
`default_nettype none
package oaht_pkg;

   localparam int TableDepth = 1024;
   localparam int SlotWidth = $clog2(TableDepth);
   localparam int CapWidth = SlotWidth + 1;
   localparam int KeyWidth = 64;
   localparam int HashWidth = 32;
   localparam int IdWidth = 16;
   localparam int QtyWidth = 16;
   localparam int DoubleHashPrime = 11;
   localparam int PrimeWidth = $clog2(DoubleHashPrime + 1);
   localparam int EntryWidth = 1 + KeyWidth + IdWidth + QtyWidth;
   localparam int BitCountWidth = $clog2(HashWidth);
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 16;
   localparam int StatusWidth = 3;

   // hash mod the prime: fold 10 bit chunks, then a reciprocal multiply
   localparam int FoldWidth = 12;
   localparam int RecipWidth = 13;
   localparam int RecipShift = 16;
   localparam logic [RecipWidth-1:0] RecipMult = 13'd5958;
   localparam int QuoWidth = FoldWidth + RecipWidth - RecipShift;

   localparam logic [CapWidth-1:0] CapReset = CapWidth'(1021);

   localparam logic [CsrIndexWidth-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PROBE_MODE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_ID = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_ID = 2'd3;

   localparam logic [1:0] MODE_QUADRATIC = 2'd0;
   localparam logic [1:0] MODE_DOUBLE = 2'd1;

   localparam logic OP_INSERT = 1'b0;

   localparam logic [StatusWidth-1:0] ST_INSERTED = 3'd0;
   localparam logic [StatusWidth-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [StatusWidth-1:0] ST_BAD_ID = 3'd2;
   localparam logic [StatusWidth-1:0] ST_FULL = 3'd3;
   localparam logic [StatusWidth-1:0] ST_FOUND = 3'd4;
   localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 3'd5;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIVIDE,
      S_REDUCE,
      S_READ,
      S_CHECK,
      S_BAD
   } state_type;

   typedef enum logic [1:0] {
      FIN_BAD,
      FIN_HIT,
      FIN_EMPTY,
      FIN_MISS
   } finish_type;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       probe_init;
      logic       reduce;
      logic       advance;
      logic       clear_step;
      logic       write;
      logic       finish;
      finish_type kind;
   } cmd_type;

   typedef struct packed {
      logic op_insert;
      logic bad_id;
      logic div_done;
      logic step_big;
      logic double_mode;
      logic hit;
      logic empty;
      logic last_probe;
      logic clear_done;
   } stat_type;

endpackage
`default_nettype wire

// File: design/oaht_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module oaht_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: design/oaht_datapath.sv
// datapath: config registers, hash divider, probe sequence, slot ram, result register
// depends on oaht_pkg and oaht_ram
`default_nettype none
module oaht_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [oaht_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [oaht_pkg::CsrDataWidth-1:0]   csr_data,
   input  wire logic                                req_opcode,
   input  wire logic [oaht_pkg::HashWidth-1:0]      req_key_hash,
   input  wire logic [oaht_pkg::KeyWidth-1:0]       req_model_key,
   input  wire logic [oaht_pkg::IdWidth-1:0]        req_dealer_id,
   input  wire logic [oaht_pkg::QtyWidth-1:0]       req_quantity_in,
   input  wire oaht_pkg::cmd_type                   cmd,
   output oaht_pkg::stat_type                       stat,
   output logic      [oaht_pkg::StatusWidth-1:0]    rsp_status,
   output logic      [oaht_pkg::QtyWidth-1:0]       rsp_quantity_out,
   output logic      [oaht_pkg::SlotWidth-1:0]      rsp_slot_index
);
   import oaht_pkg::*;

   logic [CapWidth-1:0]      cap_ff;
   logic [1:0]               mode_ff;
   logic [IdWidth-1:0]       min_id_ff;
   logic [IdWidth-1:0]       max_id_ff;

   logic                     op_ff;
   logic [HashWidth-1:0]     hash_ff;
   logic [KeyWidth-1:0]      key_ff;
   logic [IdWidth-1:0]       dealer_ff;
   logic [QtyWidth-1:0]      qty_ff;

   logic [SlotWidth-1:0]     rem_ff;
   logic [FoldWidth-1:0]     fold_ff;
   logic [QuoWidth-1:0]      quo11_ff;
   logic [PrimeWidth-1:0]    rem11_ff;
   logic [BitCountWidth-1:0] bit_ff;
   logic [SlotWidth-1:0]     slot_ff;
   logic [CapWidth-1:0]      inc_ff;
   logic [CapWidth-1:0]      count_ff;
   logic [CapWidth-1:0]      last_ff;
   logic [SlotWidth-1:0]     clr_ff;

   logic [StatusWidth-1:0]   status_ff;
   logic [QtyWidth-1:0]      qout_ff;
   logic [SlotWidth-1:0]     where_ff;

   logic [CapWidth-1:0]      cap_eff;
   logic                     probing;
   logic [CapWidth-1:0]      div_t;
   logic [SlotWidth-1:0]     rem_in;
   logic [FoldWidth-1:0]     fold_in;
   logic [FoldWidth+RecipWidth-1:0] recip_prod;
   logic [QuoWidth-1:0]      quo11_in;
   logic [FoldWidth-1:0]     rem11_full;
   logic [PrimeWidth-1:0]    rem11_in;
   logic [CapWidth-1:0]      slot_sum;
   logic [SlotWidth-1:0]     slot_in;
   logic [CapWidth:0]        inc_sum;
   logic [CapWidth-1:0]      inc_in;
   logic [EntryWidth-1:0]    rd_data;
   logic [EntryWidth-1:0]    wr_data;
   logic [SlotWidth-1:0]     wr_addr;
   logic                     wr_en;
   logic                     e_valid;
   logic [KeyWidth-1:0]      e_key;
   logic [IdWidth-1:0]       e_dealer;
   logic [QtyWidth-1:0]      e_qty;

   always_comb begin
      if (cap_ff < CapWidth'(2)) begin
         cap_eff = CapWidth'(2);
      end else if (cap_ff > CapWidth'(TableDepth)) begin
         cap_eff = CapWidth'(TableDepth);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign probing = (mode_ff == MODE_QUADRATIC) || (mode_ff == MODE_DOUBLE);

   // one quotient bit per cycle for the remainder by capacity
   assign div_t = {rem_ff, hash_ff[HashWidth-1]};
   assign rem_in = (div_t >= cap_eff) ? SlotWidth'(div_t - cap_eff) : div_t[SlotWidth-1:0];

   // 2^10 is 1 mod 11: fold the hash into 10 bit chunks, then divide the sum
   assign fold_in = FoldWidth'(req_key_hash[9:0]) + FoldWidth'(req_key_hash[19:10]) +
                    FoldWidth'(req_key_hash[29:20]) + FoldWidth'(req_key_hash[31:30]);
   assign recip_prod = (FoldWidth+RecipWidth)'(fold_ff) *
                       (FoldWidth+RecipWidth)'(RecipMult);
   assign quo11_in = recip_prod[FoldWidth+RecipWidth-1 -: QuoWidth];
   assign rem11_full = fold_ff - FoldWidth'(quo11_ff) * FoldWidth'(DoubleHashPrime);
   assign rem11_in = rem11_full[PrimeWidth-1:0];

   // next probe slot and next quadratic increment
   assign slot_sum = {1'b0, slot_ff} + inc_ff;
   assign slot_in = (slot_sum >= cap_eff) ? SlotWidth'(slot_sum - cap_eff) :
                    slot_sum[SlotWidth-1:0];
   assign inc_sum = {1'b0, inc_ff} + (CapWidth+1)'(2);
   assign inc_in = (inc_sum >= {1'b0, cap_eff}) ? CapWidth'(inc_sum - {1'b0, cap_eff}) :
                   inc_sum[CapWidth-1:0];

   assign e_valid = rd_data[EntryWidth-1];
   assign e_key = rd_data[EntryWidth-2 -: KeyWidth];
   assign e_dealer = rd_data[IdWidth+QtyWidth-1 -: IdWidth];
   assign e_qty = rd_data[QtyWidth-1:0];

   assign wr_en = cmd.clear_step || cmd.write;
   assign wr_addr = cmd.clear_step ? clr_ff : slot_ff;
   assign wr_data = cmd.clear_step ? '0 : {1'b1, key_ff, dealer_ff, qty_ff};

   oaht_ram #(
      .Width (EntryWidth),
      .Depth (TableDepth)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
         mode_ff <= MODE_QUADRATIC;
         min_id_ff <= '0;
         max_id_ff <= '1;
         clr_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CAPACITY:   cap_ff <= csr_data[CapWidth-1:0];
               CSR_PROBE_MODE: mode_ff <= csr_data[1:0];
               CSR_MIN_ID:     min_id_ff <= csr_data[IdWidth-1:0];
               CSR_MAX_ID:     max_id_ff <= csr_data[IdWidth-1:0];
               default:        ;
            endcase
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + SlotWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         hash_ff <= req_key_hash;
         key_ff <= req_model_key;
         dealer_ff <= req_dealer_id;
         qty_ff <= req_quantity_in;
         rem_ff <= '0;
         fold_ff <= fold_in;
         bit_ff <= '0;
      end else if (cmd.div_step) begin
         hash_ff <= {hash_ff[HashWidth-2:0], 1'b0};
         rem_ff <= rem_in;
         quo11_ff <= quo11_in;
         rem11_ff <= rem11_in;
         bit_ff <= bit_ff + BitCountWidth'(1);
      end
      if (cmd.probe_init) begin
         slot_ff <= rem_ff;
         count_ff <= '0;
         if (!probing) begin
            last_ff <= '0;
         end else if (op_ff == OP_INSERT) begin
            last_ff <= cap_eff;
         end else begin
            last_ff <= cap_eff - CapWidth'(1);
         end
         if (mode_ff == MODE_DOUBLE) begin
            inc_ff <= CapWidth'(DoubleHashPrime) - CapWidth'(rem11_ff);
         end else begin
            inc_ff <= CapWidth'(1);
         end
      end else if (cmd.reduce) begin
         inc_ff <= inc_ff - cap_eff;
      end else if (cmd.advance) begin
         slot_ff <= slot_in;
         count_ff <= count_ff + CapWidth'(1);
         if (mode_ff != MODE_DOUBLE) begin
            inc_ff <= inc_in;
         end
      end
      if (cmd.finish) begin
         qout_ff <= '0;
         where_ff <= '0;
         unique case (cmd.kind)
            FIN_BAD: status_ff <= ST_BAD_ID;
            FIN_HIT: begin
               status_ff <= (op_ff == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
               where_ff <= slot_ff;
               if (op_ff != OP_INSERT) begin
                  qout_ff <= e_qty;
               end
            end
            FIN_EMPTY: begin
               status_ff <= ST_INSERTED;
               where_ff <= slot_ff;
            end
            FIN_MISS: status_ff <= (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            default: status_ff <= ST_NOT_FOUND;
         endcase
      end
   end

   always_comb begin
      stat.op_insert = (op_ff == OP_INSERT);
      stat.bad_id = (dealer_ff < min_id_ff) || (dealer_ff > max_id_ff);
      stat.div_done = (bit_ff == BitCountWidth'(HashWidth - 1));
      stat.step_big = (inc_ff >= cap_eff);
      stat.double_mode = (mode_ff == MODE_DOUBLE);
      stat.hit = e_valid && (e_key == key_ff) && (e_dealer == dealer_ff);
      stat.empty = !e_valid;
      stat.last_probe = (count_ff == last_ff);
      stat.clear_done = (clr_ff == '1);
   end

   assign rsp_status = status_ff;
   assign rsp_quantity_out = qout_ff;
   assign rsp_slot_index = where_ff;

endmodule
`default_nettype wire

// File: design/oaht_control.sv
// controller: clearing pass, divide, probe and response sequencing
// depends on oaht_pkg
`default_nettype none
module oaht_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire oaht_pkg::stat_type stat,
   output oaht_pkg::cmd_type       cmd
);
   import oaht_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign out_free = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd = '0;
      cmd.kind = FIN_MISS;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_BAD;
            end
         end
         S_BAD: begin
            if (stat.op_insert && stat.bad_id) begin
               if (out_free) begin
                  cmd.finish = 1'b1;
                  cmd.kind = FIN_BAD;
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.probe_init = 1'b1;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (stat.double_mode && stat.step_big) begin
               cmd.reduce = 1'b1;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (stat.hit) begin
               if (out_free) begin
                  cmd.finish = 1'b1;
                  cmd.kind = FIN_HIT;
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (stat.op_insert && stat.empty) begin
               if (out_free) begin
                  cmd.finish = 1'b1;
                  cmd.write = 1'b1;
                  cmd.kind = FIN_EMPTY;
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (stat.last_probe) begin
               if (out_free) begin
                  cmd.finish = 1'b1;
                  cmd.kind = FIN_MISS;
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: design/open_address_hash_table.sv
// top level of the open address hash table
// depends on oaht_pkg, oaht_control, oaht_datapath and oaht_ram
//
// channel  direction  word
// req      in         tuser: opcode; tdata: key_hash, model_key, dealer_id, quantity_in
// rsp      out        tuser: status; tdata: quantity_out, slot_index
// csr      in         csr_index selects register, csr_data holds value
//
// an item runs the bit-serial remainder of the hash, then in double hashing mode brings
// the step below capacity, then reads and checks each probe slot visited in turn
// the slot ram has one read port, so probes go one at a time
// after reset a clearing pass writes every slot before the first item is taken
// a waiting response holds the next one back only at its final cycle
`default_nettype none
module open_address_hash_table (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [0:0]   req_tuser,  // opcode
   input  wire logic [127:0] req_tdata,  // key_hash, model_key, dealer_id, quantity_in
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [2:0]   rsp_tuser,  // status
   output logic      [31:0]  rsp_tdata,  // quantity_out, slot_index, zero fill
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_data
);
   import oaht_pkg::*;

   cmd_type                cmd;
   stat_type               stat;
   logic [QtyWidth-1:0]    quantity_out;
   logic [SlotWidth-1:0]   slot_index;

   assign csr_ready = 1'b1;

   oaht_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   oaht_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_opcode       (req_tuser[0]),
      .req_key_hash     (req_tdata[31:0]),
      .req_model_key    (req_tdata[95:32]),
      .req_dealer_id    (req_tdata[111:96]),
      .req_quantity_in  (req_tdata[127:112]),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_tuser),
      .rsp_quantity_out (quantity_out),
      .rsp_slot_index   (slot_index)
   );

   assign rsp_tdata = {6'b0, slot_index, quantity_out};

endmodule
`default_nettype wire
